@@ src/bpsp_pkg.sv @@
// Shared types, register codes and reset values for the battery pack safety policy.
package bpsp_pkg;

	localparam int CfgIndexWidth = 3;
	localparam int CfgDataWidth  = 16;

	localparam logic [CfgIndexWidth-1:0] REG_CRITICAL_SHIP = 3'd0;
	localparam logic [CfgIndexWidth-1:0] REG_CHARGE_STOP   = 3'd1;
	localparam logic [CfgIndexWidth-1:0] REG_CHARGE_RESUME = 3'd2;
	localparam logic [CfgIndexWidth-1:0] REG_OUTPUT_OFF    = 3'd3;
	localparam logic [CfgIndexWidth-1:0] REG_LOW_WARN      = 3'd4;
	localparam logic [CfgIndexWidth-1:0] REG_BALANCE_MIN   = 3'd5;
	localparam logic [CfgIndexWidth-1:0] REG_IDLE_CURRENT  = 3'd6;
	localparam logic [CfgIndexWidth-1:0] REG_LOAD_CURRENT  = 3'd7;

	localparam logic [12:0]        RST_CRITICAL_SHIP = 13'd3000;
	localparam logic [12:0]        RST_CHARGE_STOP   = 13'd4200;
	localparam logic [12:0]        RST_CHARGE_RESUME = 13'd4100;
	localparam logic [12:0]        RST_OUTPUT_OFF    = 13'd3200;
	localparam logic [12:0]        RST_LOW_WARN      = 13'd3400;
	localparam logic [12:0]        RST_BALANCE_MIN   = 13'd3600;
	localparam logic [14:0]        RST_IDLE_CURRENT  = 15'd50;
	localparam logic signed [15:0] RST_LOAD_CURRENT  = -16'sd50;

	// Fault word bit positions.
	localparam int FaultSensorBit = 1;

	typedef enum logic [2:0] {
		ST_SHIP         = 3'd0,
		ST_SENSOR_FAULT = 3'd1,
		ST_FAULT        = 3'd2,
		ST_BALANCING    = 3'd3,
		ST_OUTPUT_OFF   = 3'd4,
		ST_CHARGING     = 3'd5,
		ST_DISCHARGING  = 3'd6,
		ST_IDLE         = 3'd7
	} pack_state_t;

	typedef struct packed {
		logic [12:0]        critical_ship_mv;
		logic [12:0]        charge_stop_mv;
		logic [12:0]        charge_resume_mv;
		logic [12:0]        output_off_mv;
		logic [12:0]        low_warn_mv;
		logic [12:0]        balance_min_mv;
		logic [14:0]        idle_current_ma;
		logic signed [15:0] load_current_ma;
	} cfg_t;

	typedef struct packed {
		logic [12:0]        cell_a_mv;
		logic [12:0]        cell_b_mv;
		logic [12:0]        cell_c_mv;
		logic signed [15:0] current_ma;
		logic [2:0]         fault_bits;
		logic               trusted;
		logic               balancing_now;
		logic               ship_request;
		logic               charge_disabled;
		logic               discharge_disabled;
		logic               clear_idle_off;
	} snapshot_t;

	typedef struct packed {
		pack_state_t pack_state;
		logic        request_ship;
		logic        allow_charge;
		logic        allow_discharge;
		logic        allow_balancing;
		logic        low_cell_fault;
	} verdict_t;

endpackage

@@ src/bpsp_cfg.sv @@
// Threshold register file written through the plain configuration port.
module bpsp_cfg
	import bpsp_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_wen,
	input  logic [CfgIndexWidth-1:0] cfg_index,
	input  logic [CfgDataWidth-1:0]  cfg_data,
	output cfg_t                     cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.critical_ship_mv <= RST_CRITICAL_SHIP;
			cfg_q.charge_stop_mv   <= RST_CHARGE_STOP;
			cfg_q.charge_resume_mv <= RST_CHARGE_RESUME;
			cfg_q.output_off_mv    <= RST_OUTPUT_OFF;
			cfg_q.low_warn_mv      <= RST_LOW_WARN;
			cfg_q.balance_min_mv   <= RST_BALANCE_MIN;
			cfg_q.idle_current_ma  <= RST_IDLE_CURRENT;
			cfg_q.load_current_ma  <= RST_LOAD_CURRENT;
		end else if (cfg_wen) begin
			unique case (cfg_index)
				REG_CRITICAL_SHIP: cfg_q.critical_ship_mv <= cfg_data[12:0];
				REG_CHARGE_STOP:   cfg_q.charge_stop_mv   <= cfg_data[12:0];
				REG_CHARGE_RESUME: cfg_q.charge_resume_mv <= cfg_data[12:0];
				REG_OUTPUT_OFF:    cfg_q.output_off_mv    <= cfg_data[12:0];
				REG_LOW_WARN:      cfg_q.low_warn_mv      <= cfg_data[12:0];
				REG_BALANCE_MIN:   cfg_q.balance_min_mv   <= cfg_data[12:0];
				REG_IDLE_CURRENT:  cfg_q.idle_current_ma  <= cfg_data[14:0];
				REG_LOAD_CURRENT:  cfg_q.load_current_ma  <= signed'(cfg_data);
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

@@ src/bpsp_core.sv @@
// Policy evaluation of one snapshot, with the charge, discharge and idle-off latches.
module bpsp_core
	import bpsp_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      en,
	input  snapshot_t snap,
	input  cfg_t      cfg,
	output verdict_t  verdict
);

	logic chg_off_q, dis_off_q, idle_off_q;
	logic chg_off_d, dis_off_d, idle_off_d;

	logic [12:0]        lo_ab, hi_ab, lo, hi;
	logic signed [16:0] cur_x, idle_x, load_x;
	logic [16:0]        mag;
	logic               ship;

	always_comb begin
		lo_ab = (snap.cell_b_mv < snap.cell_a_mv) ? snap.cell_b_mv : snap.cell_a_mv;
		lo    = (snap.cell_c_mv < lo_ab) ? snap.cell_c_mv : lo_ab;
		hi_ab = (snap.cell_b_mv > snap.cell_a_mv) ? snap.cell_b_mv : snap.cell_a_mv;
		hi    = (snap.cell_c_mv > hi_ab) ? snap.cell_c_mv : hi_ab;

		cur_x  = {snap.current_ma[15], snap.current_ma};
		idle_x = signed'({2'b00, cfg.idle_current_ma});
		load_x = {cfg.load_current_ma[15], cfg.load_current_ma};
		mag    = cur_x[16] ? unsigned'(-cur_x) : unsigned'(cur_x);

		ship = snap.ship_request || (lo <= cfg.critical_ship_mv);

		// The clear request acts first, even on ship and fault snapshots.
		chg_off_d  = chg_off_q;
		dis_off_d  = dis_off_q;
		idle_off_d = snap.clear_idle_off ? 1'b0 : idle_off_q;

		verdict = '0;

		if (ship) begin
			verdict.request_ship = 1'b1;
			verdict.pack_state   = ST_SHIP;
		end else if (snap.fault_bits != 3'd0) begin
			verdict.pack_state = snap.fault_bits[FaultSensorBit] ? ST_SENSOR_FAULT : ST_FAULT;
		end else begin
			// Set tests win over release tests when thresholds cross.
			if (hi >= cfg.charge_stop_mv) begin
				chg_off_d = 1'b1;
			end else if (hi <= cfg.charge_resume_mv) begin
				chg_off_d = 1'b0;
			end

			if (lo <= cfg.output_off_mv) begin
				dis_off_d              = 1'b1;
				idle_off_d             = 1'b1;
				verdict.low_cell_fault = 1'b1;
			end else if (lo >= cfg.low_warn_mv) begin
				dis_off_d = 1'b0;
			end

			verdict.allow_charge    = !snap.charge_disabled && !chg_off_d;
			verdict.allow_discharge = !snap.discharge_disabled && !dis_off_d && !idle_off_d;
			verdict.allow_balancing = snap.trusted && !snap.charge_disabled
				&& (lo >= cfg.balance_min_mv) && (mag <= {2'b00, cfg.idle_current_ma});

			if (snap.balancing_now) begin
				verdict.pack_state = ST_BALANCING;
			end else if (idle_off_d) begin
				verdict.pack_state = ST_OUTPUT_OFF;
			end else if (cur_x > idle_x) begin
				verdict.pack_state = ST_CHARGING;
			end else if (cur_x < load_x) begin
				verdict.pack_state = ST_DISCHARGING;
			end else begin
				verdict.pack_state = ST_IDLE;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chg_off_q  <= 1'b0;
			dis_off_q  <= 1'b0;
			idle_off_q <= 1'b0;
		end else if (en) begin
			chg_off_q  <= chg_off_d;
			dis_off_q  <= dis_off_d;
			idle_off_q <= idle_off_d;
		end
	end

endmodule

@@ src/battery_pack_safety_policy.sv @@
// Top level of the battery pack safety policy: input register, evaluation and result register.
//
// Each transfer on the input channel carries one pack snapshot and yields exactly one
// verdict on the output channel, in order. The block takes a snapshot in every clock
// cycle while the output is not stalled: a snapshot is held in the input register, is
// evaluated by a short compare-and-select path that also updates the charge-off,
// discharge-off and sticky idle-off latches, and lands in the result register, from
// which its verdict is offered on the output.
// The latches move only when a snapshot passes into the result register, which keeps
// them in step with the verdict order under any stall pattern.
// Threshold registers reset to their nominal values and are written through the plain
// write port; the user must write them only while the block is idle; the block does not enforce it.
module battery_pack_safety_policy
	import bpsp_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  snapshot_t                in_data,
	output logic                     out_valid,
	input  logic                     out_stall,
	output verdict_t                 out_data,
	input  logic                     cfg_wen,
	input  logic [CfgIndexWidth-1:0] cfg_index,
	input  logic [CfgDataWidth-1:0]  cfg_data
);

	cfg_t      cfg;
	snapshot_t snap_s1;
	logic      valid_s1;
	verdict_t  verdict;
	verdict_t  verdict_s2;
	logic      valid_s2;
	logic      adv_s2;
	logic      load_s1;

	bpsp_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// The result register can take a new verdict when empty or when its verdict leaves.
	assign adv_s2   = !valid_s2 || !out_stall;
	assign load_s1  = !valid_s1 || adv_s2;
	assign in_stall = !load_s1;

	bpsp_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (valid_s1 && adv_s2),
		.snap    (snap_s1),
		.cfg     (cfg),
		.verdict (verdict)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (load_s1) begin
				valid_s1 <= in_valid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1 && in_valid) begin
			snap_s1 <= in_data;
		end
		if (adv_s2 && valid_s1) begin
			verdict_s2 <= verdict;
		end
	end

	assign out_valid = valid_s2;
	assign out_data  = verdict_s2;

endmodule
